// ===== hw/rtl/bltr_pkg.sv =====
// Shared constants, codes and control types of the rectangle blit engine.
package bltr_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PIXEL_BITS    = 16;
  localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(STORE_SIZE);

  localparam int COORD_W  = 6;
  localparam int SIZE_W   = 7;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 16;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [OP_W-1:0] OP_V2B  = 3'd0;
  localparam logic [OP_W-1:0] OP_B2V  = 3'd1;
  localparam logic [OP_W-1:0] OP_V2V  = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL = 3'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_BLIT = 2'd2;

  typedef struct packed {
    logic clear;
    logic accept;
    logic finish_read;
    logic out_load;
  } bltr_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_read;
  } bltr_stat_t;

endpackage

// ===== hw/rtl/bltr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bltr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bltr_ctrl.sv =====
// Control state machine of the rectangle blit engine.
module bltr_ctrl
  import bltr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  bltr_stat_t stat,
  output bltr_cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_POST  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.clear       = (state == ST_CLEAR);
    cmd.accept      = (state == ST_IDLE) && in_valid;
    cmd.finish_read = (state == ST_READ);
    cmd.out_load    = (state == ST_POST) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.need_read ? ST_READ : ST_POST;
        end
      end
      ST_READ: begin
        state_next = ST_POST;
      end
      ST_POST: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("input taken during the store clearing sweep");

  a_read_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && stat.need_read) |=> (state == ST_READ))
    else $error("read step did not enter the read state");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("controller stayed idle after a transfer");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting result");

endmodule

// ===== hw/rtl/bltr_dp.sv =====
// Datapath of the rectangle blit engine: blit registers, walker, frame store and result.
module bltr_dp
  import bltr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  bltr_cmd_t           cmd,
  output bltr_stat_t          stat,
  input  logic                command,
  input  logic [OP_W-1:0]     operation,
  input  logic [COORD_W-1:0]  source_x,
  input  logic [COORD_W-1:0]  source_y,
  input  logic [COORD_W-1:0]  dest_x,
  input  logic [COORD_W-1:0]  dest_y,
  input  logic [SIZE_W-1:0]   rect_width,
  input  logic [SIZE_W-1:0]   rect_height,
  input  logic [FIELD_W-1:0]  pixel_in,
  output logic [STATUS_W-1:0] status,
  output logic [FIELD_W-1:0]  pixel_out,
  output logic                pixel_valid,
  output logic                last
);

  logic                  active;
  logic [1:0]            act_op;
  logic [COORD_W-1:0]    sx, sy, dx, dy;
  logic [SIZE_W-1:0]     w, h;
  logic [SIZE_W-1:0]     walk_col, walk_row;
  logic [1:0]            dir;
  logic [PIXEL_BITS-1:0] fill;
  logic [ADDR_W-1:0]     clear_cnt;

  logic [STATUS_W-1:0]   res_status;
  logic [FIELD_W-1:0]    res_pixel;
  logic                  res_pvalid;
  logic                  res_last;

  logic [SIZE_W-1:0]     row_m, col_m;
  logic [SIZE_W-1:0]     src_yy, src_xx, dst_yy, dst_xx;
  logic [ADDR_W-1:0]     src_addr, dst_addr;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [PIXEL_BITS-1:0] wdata;
  logic [PIXEL_BITS-1:0] rdata;

  logic                  col_wrap, row_wrap, fin;
  logic                  src_video, dst_video, src_fits, dst_fits, start_ok;
  logic                  step_now, advance;

  assign row_m  = dir[0] ? (h - SIZE_W'(1) - walk_row) : walk_row;
  assign col_m  = dir[1] ? (w - SIZE_W'(1) - walk_col) : walk_col;
  assign src_yy = SIZE_W'(sy) + row_m;
  assign src_xx = SIZE_W'(sx) + col_m;
  assign dst_yy = SIZE_W'(dy) + row_m;
  assign dst_xx = SIZE_W'(dx) + col_m;
  assign src_addr = ADDR_W'(src_yy) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(src_xx);
  assign dst_addr = ADDR_W'(dst_yy) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(dst_xx);

  assign col_wrap = ({1'b0, walk_col} + (SIZE_W + 1)'(1)) >= {1'b0, w};
  assign row_wrap = ({1'b0, walk_row} + (SIZE_W + 1)'(1)) >= {1'b0, h};
  assign fin      = col_wrap && row_wrap;

  assign src_video = (operation == OP_V2B) || (operation == OP_V2V);
  assign dst_video = (operation == OP_B2V) || (operation == OP_V2V) ||
                     (operation == OP_FILL);
  assign src_fits  = (({2'b0, source_x} + {1'b0, rect_width}) <= (SIZE_W + 1)'(SCREEN_WIDTH)) &&
                     (({2'b0, source_y} + {1'b0, rect_height}) <= (SIZE_W + 1)'(SCREEN_HEIGHT));
  assign dst_fits  = (({2'b0, dest_x} + {1'b0, rect_width}) <= (SIZE_W + 1)'(SCREEN_WIDTH)) &&
                     (({2'b0, dest_y} + {1'b0, rect_height}) <= (SIZE_W + 1)'(SCREEN_HEIGHT));
  assign start_ok  = (operation <= OP_FILL) && (!src_video || src_fits) &&
                     (!dst_video || dst_fits);

  assign stat.need_read = (command == CMD_STEP) && active &&
                          ((act_op == OP_V2B[1:0]) || (act_op == OP_V2V[1:0]));
  assign stat.clear_last = (clear_cnt == ADDR_W'(STORE_SIZE - 1));

  assign step_now = cmd.accept && (command == CMD_STEP) && active && !stat.need_read;
  assign advance  = step_now || cmd.finish_read;

  always_comb begin
    we    = 1'b0;
    waddr = dst_addr;
    wdata = fill;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clear_cnt;
      wdata = '0;
    end else if (step_now) begin
      we    = 1'b1;
      wdata = (act_op == OP_B2V[1:0]) ? PIXEL_BITS'(pixel_in) : fill;
    end else if (cmd.finish_read && (act_op == OP_V2V[1:0])) begin
      we    = 1'b1;
      wdata = rdata;
    end
  end

  bltr_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (src_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      clear_cnt <= '0;
    end else begin
      if (cmd.clear) begin
        clear_cnt <= clear_cnt + ADDR_W'(1);
      end
      if (cmd.accept && (command == CMD_START) && start_ok) begin
        active <= (rect_width != '0) && (rect_height != '0);
      end else if (advance && fin) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (command == CMD_START) && start_ok) begin
      act_op   <= operation[1:0];
      sx       <= source_x;
      sy       <= source_y;
      dx       <= dest_x;
      dy       <= dest_y;
      w        <= rect_width;
      h        <= rect_height;
      walk_col <= '0;
      walk_row <= '0;
      fill     <= PIXEL_BITS'(pixel_in);
      dir[0]   <= (operation == OP_V2V) && !(dest_y < source_y);
      dir[1]   <= (operation == OP_V2V) && (dest_y == source_y) && (dest_x > source_x);
    end else if (advance) begin
      if (col_wrap) begin
        walk_col <= '0;
        walk_row <= row_wrap ? '0 : walk_row + SIZE_W'(1);
      end else begin
        walk_col <= walk_col + SIZE_W'(1);
      end
    end

    if (cmd.accept) begin
      res_pixel  <= '0;
      res_pvalid <= 1'b0;
      res_last   <= 1'b0;
      if (command == CMD_START) begin
        res_status <= start_ok ? STATUS_OK : STATUS_INVALID;
      end else if (!active) begin
        res_status <= STATUS_NO_BLIT;
      end else begin
        res_status <= STATUS_OK;
        res_last   <= fin;
      end
    end else if (cmd.finish_read) begin
      res_status <= STATUS_OK;
      res_last   <= fin;
      if (act_op == OP_V2B[1:0]) begin
        res_pixel  <= FIELD_W'(rdata);
        res_pvalid <= 1'b1;
      end
    end

    if (cmd.out_load) begin
      status      <= res_status;
      pixel_out   <= res_pixel;
      pixel_valid <= res_pvalid;
      last        <= res_last;
    end
  end

endmodule

// ===== hw/rtl/rectangle_blit_engine_top.sv =====
// Top level of the rectangle blit engine.
//
// The input channel carries commands: a start transfer sets up a blit (operation,
// corners, size and fill color) and each step transfer handles one pixel of it,
// walking the rectangle row by row. Every input transfer yields exactly one
// result transfer with status, pixel_out, pixel_valid and last.
// A start, a step with no active blit, and a step of a write or fill blit go
// from the idle state straight to the post state, where the result is loaded.
// Read-out and copy steps pass through the read state first, because the frame
// store has a registered read port. One item is in flight at a time; the
// controller is back in its idle state once the result is loaded into the
// output register. After reset the frame store is swept to zero, one pixel per
// cycle; in_ready stays low during the sweep.
// When the receiver stalls, one result waits in the output register while the
// next item is accepted and worked; that item's result then waits until the
// output register frees up, and no further item is accepted meanwhile.
module rectangle_blit_engine_top
  import bltr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [OP_W-1:0]     operation,
  input  logic [COORD_W-1:0]  source_x,
  input  logic [COORD_W-1:0]  source_y,
  input  logic [COORD_W-1:0]  dest_x,
  input  logic [COORD_W-1:0]  dest_y,
  input  logic [SIZE_W-1:0]   rect_width,
  input  logic [SIZE_W-1:0]   rect_height,
  input  logic [FIELD_W-1:0]  pixel_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [FIELD_W-1:0]  pixel_out,
  output logic                pixel_valid,
  output logic                last
);

  bltr_cmd_t  cmd;
  bltr_stat_t stat;

  bltr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bltr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .command     (command),
    .operation   (operation),
    .source_x    (source_x),
    .source_y    (source_y),
    .dest_x      (dest_x),
    .dest_y      (dest_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .pixel_in    (pixel_in),
    .status      (status),
    .pixel_out   (pixel_out),
    .pixel_valid (pixel_valid),
    .last        (last)
  );

endmodule
